[rtl/lobm_pkg.sv]
// Shared constants, codes and record types for the limit order book matcher.
`default_nettype none
package lobm_pkg;
   localparam int NUM_SLOTS = 64;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int CNT_W     = SLOT_W + 1;
   localparam int ID_W      = 32;
   localparam int QTY_W     = 32;
   localparam int PRICE_W   = 10;
   localparam int STAMP_W   = 48;
   localparam int STATUS_W  = 3;

   localparam logic             OP_ADD         = 1'b0;
   localparam logic             OP_CANCEL      = 1'b1;
   localparam logic             SIDE_BUY       = 1'b0;
   localparam logic             SIDE_SELL      = 1'b1;
   localparam logic             KIND_LIMIT     = 1'b0;
   localparam logic             KIND_MARKET    = 1'b1;
   localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_RESTED    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_CANCELLED = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_FILL,
      ST_FINAL,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [QTY_W-1:0]   qty;
      logic [PRICE_W-1:0] price;
      logic               side;
      logic [STAMP_W-1:0] stamp;
   } slot_type;

   typedef struct packed {
      logic [ID_W-1:0]    buy_id;
      logic [ID_W-1:0]    sell_id;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } fill_type;
endpackage
`default_nettype wire

[rtl/limit_order_book_matcher_core.sv]
// Price-time priority limit order book with matching: top level.
//
// Usage: one request beat on req_* (add or cancel) is taken when req_valid is
// high and req_stall is low. req_stall stays high from acceptance until the
// last result beat of that request has been taken, so one request is in
// flight at a time. The block answers with one rsp_* beat per fill, then ends
// with rsp_last; a request with no fill gets one beat with rsp_has_trade 0.
// Every beat carries best bid and ask as they stand after the whole request.
// Each pass reads the 64 order slots one by one through the single read port
// of the slot memory. A request costs (fills + 2) passes plus the decision
// steps, then each result beat is first read from the fill buffer and then
// offered, moving on only while rsp_stall is low. The next request can be
// taken the cycle after the last beat. The slot scan is the bottleneck. When
// the receiver stalls, the current beat holds and the sequencer waits. Reset
// (synchronous, active high) empties the book by clearing the slot used bits
// and returns to idle; slot contents need no clearing pass.
`default_nettype none
module limit_order_book_matcher_core
   import lobm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_op,
   input  wire logic [ID_W-1:0]     req_ident,
   input  wire logic                req_side,
   input  wire logic                req_order_kind,
   input  wire logic [PRICE_W-1:0]  req_price_tick,
   input  wire logic [QTY_W-1:0]    req_quantity,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_has_trade,
   output logic [ID_W-1:0]          rsp_buy_id,
   output logic [ID_W-1:0]          rsp_sell_id,
   output logic [PRICE_W-1:0]       rsp_fill_price,
   output logic [QTY_W-1:0]         rsp_trade_qty,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [PRICE_W-1:0]       rsp_top_bid,
   output logic                     rsp_bid_present,
   output logic [PRICE_W-1:0]       rsp_top_ask,
   output logic                     rsp_ask_present,
   output logic                     rsp_last
);

   // Sequencer and latched request.
   state_type            state_ff, state_in;
   logic                 op_ff, op_in;
   logic                 side_ff, side_in;
   logic                 kind_ff, kind_in;
   logic [PRICE_W-1:0]   price_ff, price_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [QTY_W-1:0]     qty_ff, qty_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;
   logic [NUM_SLOTS-1:0] used_ff, used_in;

   // Scan pipeline.
   logic [CNT_W-1:0]     scan_cnt_ff, scan_cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0]    rd_idx_ff, rd_idx_in;
   slot_type             slot_rd_ff;

   // Scan results.
   logic                 opp_found_ff, opp_found_in;
   logic [SLOT_W-1:0]    opp_idx_ff, opp_idx_in;
   slot_type             opp_rec_ff, opp_rec_in;
   logic                 free_found_ff, free_found_in;
   logic [SLOT_W-1:0]    free_idx_ff, free_idx_in;
   logic                 hit_found_ff, hit_found_in;
   logic [SLOT_W-1:0]    hit_idx_ff, hit_idx_in;
   logic                 bid_found_ff, bid_found_in;
   logic [PRICE_W-1:0]   bid_max_ff, bid_max_in;
   logic                 ask_found_ff, ask_found_in;
   logic [PRICE_W-1:0]   ask_min_ff, ask_min_in;

   // Result emission.
   logic [SLOT_W-1:0]    emit_idx_ff, emit_idx_in;
   fill_type             fb_rd_ff;

   // Memories.
   slot_type             slot_mem [NUM_SLOTS];
   fill_type             fb_mem   [NUM_SLOTS];
   logic                 slot_we;
   logic [SLOT_W-1:0]    slot_waddr;
   slot_type             slot_wdata;
   logic                 fb_we;
   logic [SLOT_W-1:0]    fb_waddr;
   fill_type             fb_wdata;

   logic                 scan_done;
   logic                 is_last;
   logic                 opp_side;
   logic                 better;
   logic                 price_ok;
   logic [QTY_W-1:0]     tq;

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[scan_cnt_ff[SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (fb_we) begin
         fb_mem[fb_waddr] <= fb_wdata;
      end
      fb_rd_ff <= fb_mem[emit_idx_ff];
   end

   assign scan_done = scan_cnt_ff[SLOT_W] && !rd_vld_ff;
   assign opp_side  = ~side_ff;
   assign is_last   = (cnt_ff == '0) || (({1'b0, emit_idx_ff} + 1'b1) == cnt_ff);
   assign tq        = (qty_ff < opp_rec_ff.qty) ? qty_ff : opp_rec_ff.qty;
   assign price_ok  = (kind_ff == KIND_MARKET) ||
                      ((side_ff == SIDE_BUY) ? !(price_ff < opp_rec_ff.price)
                                             : !(price_ff > opp_rec_ff.price));

   // Candidate beats the best resting opposite order so far: better price,
   // or same price and older arrival stamp (head of the level's queue).
   always_comb begin
      if (!opp_found_ff) begin
         better = 1'b1;
      end else if (opp_side == SIDE_SELL) begin
         better = (slot_rd_ff.price < opp_rec_ff.price) ||
                  ((slot_rd_ff.price == opp_rec_ff.price) &&
                   (slot_rd_ff.stamp < opp_rec_ff.stamp));
      end else begin
         better = (slot_rd_ff.price > opp_rec_ff.price) ||
                  ((slot_rd_ff.price == opp_rec_ff.price) &&
                   (slot_rd_ff.stamp < opp_rec_ff.stamp));
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      side_in       = side_ff;
      kind_in       = kind_ff;
      price_in      = price_ff;
      id_in         = id_ff;
      qty_in        = qty_ff;
      cnt_in        = cnt_ff;
      status_in     = status_ff;
      stamp_in      = stamp_ff;
      used_in       = used_ff;
      scan_cnt_in   = scan_cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = scan_cnt_ff[SLOT_W-1:0];
      opp_found_in  = opp_found_ff;
      opp_idx_in    = opp_idx_ff;
      opp_rec_in    = opp_rec_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      bid_found_in  = bid_found_ff;
      bid_max_in    = bid_max_ff;
      ask_found_in  = ask_found_ff;
      ask_min_in    = ask_min_ff;
      emit_idx_in   = emit_idx_ff;
      slot_we       = 1'b0;
      slot_waddr    = opp_idx_ff;
      slot_wdata    = opp_rec_ff;
      fb_we         = 1'b0;
      fb_waddr      = cnt_ff[SLOT_W-1:0];
      fb_wdata      = '0;

      // Fold in the slot that returned from memory.
      if (rd_vld_ff) begin
         if (used_ff[rd_idx_ff]) begin
            if ((slot_rd_ff.side == opp_side) && better) begin
               opp_found_in = 1'b1;
               opp_idx_in   = rd_idx_ff;
               opp_rec_in   = slot_rd_ff;
            end
            if ((slot_rd_ff.id == id_ff) && !hit_found_ff) begin
               hit_found_in = 1'b1;
               hit_idx_in   = rd_idx_ff;
            end
            if (slot_rd_ff.side == SIDE_BUY) begin
               if (!bid_found_ff || (slot_rd_ff.price > bid_max_ff)) begin
                  bid_found_in = 1'b1;
                  bid_max_in   = slot_rd_ff.price;
               end
            end else begin
               if (!ask_found_ff || (slot_rd_ff.price < ask_min_ff)) begin
                  ask_found_in = 1'b1;
                  ask_min_in   = slot_rd_ff.price;
               end
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in       = req_op;
               side_in     = req_side;
               kind_in     = req_order_kind;
               price_in    = req_price_tick;
               id_in       = req_ident;
               qty_in      = req_quantity;
               cnt_in      = '0;
               status_in   = STAT_DONE;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN, ST_FINAL: begin
            if (!scan_cnt_ff[SLOT_W]) begin
               rd_vld_in   = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
            if (scan_done) begin
               state_in = (state_ff == ST_SCAN) ? ST_DECIDE : ST_EMIT_RD;
               emit_idx_in = '0;
            end
         end
         ST_DECIDE: begin
            state_in = ST_FINAL;
            if (op_ff == OP_CANCEL) begin
               if (hit_found_ff) begin
                  used_in[hit_idx_ff] = 1'b0;
                  status_in           = STAT_CANCELLED;
               end else begin
                  status_in = STAT_NOT_FOUND;
               end
            end else if ((qty_ff != '0) && !cnt_ff[SLOT_W] && opp_found_ff && price_ok) begin
               state_in = ST_FILL;
            end else if ((qty_ff != '0) && (kind_ff == KIND_LIMIT)) begin
               if (free_found_ff) begin
                  slot_we              = 1'b1;
                  slot_waddr           = free_idx_ff;
                  slot_wdata.id        = id_ff;
                  slot_wdata.qty       = qty_ff;
                  slot_wdata.price     = price_ff;
                  slot_wdata.side      = side_ff;
                  slot_wdata.stamp     = stamp_ff;
                  used_in[free_idx_ff] = 1'b1;
                  stamp_in             = stamp_ff + 1'b1;
                  status_in            = STAT_RESTED;
               end else begin
                  status_in = STAT_FULL;
               end
            end
         end
         ST_FILL: begin
            fb_we            = 1'b1;
            fb_wdata.buy_id  = (side_ff == SIDE_BUY) ? id_ff : opp_rec_ff.id;
            fb_wdata.sell_id = (side_ff == SIDE_BUY) ? opp_rec_ff.id : id_ff;
            fb_wdata.price   = opp_rec_ff.price;
            fb_wdata.qty     = tq;
            slot_we          = 1'b1;
            slot_wdata.qty   = opp_rec_ff.qty - tq;
            if (opp_rec_ff.qty == tq) begin
               used_in[opp_idx_ff] = 1'b0;
            end
            qty_in   = qty_ff - tq;
            cnt_in   = cnt_ff + 1'b1;
            state_in = ST_SCAN;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (!rsp_stall) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + 1'b1;
                  state_in    = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Restart the scan and its results when a pass is about to begin.
      if ((state_in == ST_SCAN || state_in == ST_FINAL) &&
          !(state_ff == ST_SCAN || state_ff == ST_FINAL)) begin
         scan_cnt_in   = '0;
         opp_found_in  = 1'b0;
         free_found_in = 1'b0;
         hit_found_in  = 1'b0;
         bid_found_in  = 1'b0;
         ask_found_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         scan_cnt_ff   <= '0;
         stamp_ff      <= '0;
         cnt_ff        <= '0;
         emit_idx_ff   <= '0;
         opp_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         hit_found_ff  <= 1'b0;
         bid_found_ff  <= 1'b0;
         ask_found_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         rd_vld_ff     <= rd_vld_in;
         scan_cnt_ff   <= scan_cnt_in;
         stamp_ff      <= stamp_in;
         cnt_ff        <= cnt_in;
         emit_idx_ff   <= emit_idx_in;
         opp_found_ff  <= opp_found_in;
         free_found_ff <= free_found_in;
         hit_found_ff  <= hit_found_in;
         bid_found_ff  <= bid_found_in;
         ask_found_ff  <= ask_found_in;
      end
      op_ff       <= op_in;
      side_ff     <= side_in;
      kind_ff     <= kind_in;
      price_ff    <= price_in;
      id_ff       <= id_in;
      qty_ff      <= qty_in;
      status_ff   <= status_in;
      rd_idx_ff   <= rd_idx_in;
      opp_idx_ff  <= opp_idx_in;
      opp_rec_ff  <= opp_rec_in;
      free_idx_ff <= free_idx_in;
      hit_idx_ff  <= hit_idx_in;
      bid_max_ff  <= bid_max_in;
      ask_min_ff  <= ask_min_in;
   end

   // Result beat: fill data from the fill buffer, book tops from the final pass.
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_EMIT_OUT);
   assign rsp_has_trade   = (cnt_ff != '0);
   assign rsp_buy_id      = rsp_has_trade ? fb_rd_ff.buy_id  : '0;
   assign rsp_sell_id     = rsp_has_trade ? fb_rd_ff.sell_id : '0;
   assign rsp_fill_price  = rsp_has_trade ? fb_rd_ff.price   : '0;
   assign rsp_trade_qty   = rsp_has_trade ? fb_rd_ff.qty     : '0;
   assign rsp_last        = is_last;
   assign rsp_status      = is_last ? status_ff : STAT_DONE;
   assign rsp_top_bid     = bid_found_ff ? bid_max_ff : '0;
   assign rsp_bid_present = bid_found_ff;
   assign rsp_top_ask     = ask_found_ff ? ask_min_ff : '0;
   assign rsp_ask_present = ask_found_ff;

   // A result is never offered while a new request could be taken.
   a_rsp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("result offered while idle");

   // Fill count never passes the slot count.
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(NUM_SLOTS))
      else $error("fill count overflow");

   // A beat without a fill is always the only and final one.
   a_notrade_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_trade) |-> rsp_last)
      else $error("tradeless beat not last");

   // After the final beat is taken the block is idle again.
   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !req_stall)
      else $error("not idle after last beat");
endmodule
`default_nettype wire
